// ===== sv/skyglr_pkg.sv =====
// Shared types, constants and fixed-point helpers for the sky gradient / sun glare block.
// No dependencies; imported by skyglr_sqrt, skyglr_div and sky_gradient_sun_glare_top.
`timescale 1ns / 1ps

package skyglr_pkg;

    localparam int DIR_BITS_DEF = 16;
    localparam int NORM_W       = 16;
    localparam int LEN_W        = 25;
    localparam int QUO_W        = 19;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int COLOR_W      = 16;
    localparam int PW_STAGES    = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SUN_X = 2'd0,
        CFG_SUN_Y = 2'd1,
        CFG_SUN_Z = 2'd2
    } cfg_idx_t;

    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [15:0] SUN_Z_RST = 16'd16384;

    localparam logic [15:0] C_WHITE = 16'd8192;
    localparam logic [15:0] TOP_R   = 16'd1638;
    localparam logic [15:0] TOP_G   = 16'd3277;
    localparam logic [15:0] TOP_B   = 16'd6554;
    localparam logic [15:0] GLR_R   = 16'd40960;
    localparam logic [15:0] GLR_G   = 16'd32768;
    localparam logic [15:0] GLR_B   = 16'd16384;
    localparam logic [15:0] BLM_R   = 16'd4096;
    localparam logic [15:0] BLM_G   = 16'd2458;
    localparam logic [15:0] BLM_B   = 16'd819;

    typedef struct packed {
        logic [8:0][16:0] p;
        logic [16:0]      acc;
        logic [16:0]      bloom;
        logic [16:0]      t;
        logic             zero;
    } pw_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               zero;
    } pix_t;

    function automatic logic [16:0] qmul(input logic [16:0] a, input logic [16:0] b);
        logic [33:0] pr;
        pr = 34'(a) * 34'(b);
        return 17'((pr + 34'd32768) >> 16);
    endfunction

    // one squaring or chain multiply per stage; stage 4 also forms the bloom product
    function automatic pw_t pw_step(input int unsigned k, input pw_t s);
        pw_t o;
        o = s;
        case (k)
            1: o.p[1] = qmul(s.p[0], s.p[0]);
            2: o.p[2] = qmul(s.p[1], s.p[1]);
            3: o.p[3] = qmul(s.p[2], s.p[2]);
            4:
            begin
                o.p[4]  = qmul(s.p[3], s.p[3]);
                o.bloom = qmul(s.p[3], s.p[1]);
            end
            5: o.p[5] = qmul(s.p[4], s.p[4]);
            6: o.p[6] = qmul(s.p[5], s.p[5]);
            7: o.p[7] = qmul(s.p[6], s.p[6]);
            8: o.p[8] = qmul(s.p[7], s.p[7]);
            9: o.acc  = qmul(s.p[8], s.p[7]);
            10: o.acc = qmul(s.acc, s.p[6]);
            11: o.acc = qmul(s.acc, s.p[5]);
            12: o.acc = qmul(s.acc, s.p[4]);
            13: o.acc = qmul(s.acc, s.p[2]);
            default: o = s;
        endcase
        return o;
    endfunction

    function automatic logic [15:0] blend(input logic [15:0] top, input logic [16:0] t);
        logic [31:0] acc;
        acc = 32'(C_WHITE) * 32'(ONE_Q16 - t) + 32'(top) * 32'(t) + 32'd32768;
        return acc[31:16];
    endfunction

    function automatic logic [15:0] scale(input logic [15:0] coef, input logic [16:0] x);
        logic [32:0] pr;
        pr = 33'(coef) * 33'(x) + 33'd32768;
        return 16'(pr >> 16);
    endfunction

    function automatic logic [15:0] sat_sum(input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] c);
        logic [17:0] s;
        s = 18'(a) + 18'(b) + 18'(c);
        return (s > 18'd65535) ? 16'hFFFF : s[15:0];
    endfunction

endpackage

// ===== sv/skyglr_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on skyglr_pkg.
`timescale 1ns / 1ps

module skyglr_sqrt #(
    parameter int ROOT_W = skyglr_pkg::LEN_W
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [2*ROOT_W-1:0]   rad,
    output logic [ROOT_W-1:0]     root
);
    import skyglr_pkg::*;

    localparam int RW = ROOT_W + 2;

    logic [RW-1:0]       rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]   q_reg    [ROOT_W];
    logic [2*ROOT_W-1:0] n_reg    [ROOT_W];
    logic [RW-1:0]       rem_next [ROOT_W];
    logic [ROOT_W-1:0]   q_next   [ROOT_W];
    logic [2*ROOT_W-1:0] n_next   [ROOT_W];

    always_comb
    begin
        logic [RW-1:0]       pr;
        logic [ROOT_W-1:0]   pq;
        logic [2*ROOT_W-1:0] pn;
        logic [RW-1:0]       cand;
        logic [RW-1:0]       trial;
        for (int s = 0; s < ROOT_W; s++)
        begin
            if (s == 0)
            begin
                pr = '0;
                pq = '0;
                pn = rad;
            end
            else
            begin
                pr = rem_reg[s-1];
                pq = q_reg[s-1];
                pn = n_reg[s-1];
            end
            cand      = {pr[RW-3:0], pn[2*ROOT_W-1 -: 2]};
            trial     = {pq, 2'b01};
            n_next[s] = pn << 2;
            if (cand >= trial)
            begin
                rem_next[s] = cand - trial;
                q_next[s]   = {pq[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = cand;
                q_next[s]   = {pq[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < ROOT_W; s++)
            begin
                rem_reg[s] <= rem_next[s];
                q_reg[s]   <= q_next[s];
                n_reg[s]   <= n_next[s];
            end
        end
    end

    assign root = q_reg[ROOT_W-1];

endmodule

// ===== sv/skyglr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage; quotient must fit QUO_W bits.
// Depends on skyglr_pkg.
`timescale 1ns / 1ps

module skyglr_div #(
    parameter int DEN_W = skyglr_pkg::LEN_W,
    parameter int QUO_W = skyglr_pkg::QUO_W
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [DEN_W+QUO_W-1:0]   num,
    input  logic [DEN_W-1:0]         den,
    output logic [QUO_W-1:0]         quo
);
    import skyglr_pkg::*;

    localparam int NW = DEN_W + QUO_W;

    logic [NW-1:0]    r_reg  [QUO_W];
    logic [DEN_W-1:0] d_reg  [QUO_W];
    logic [QUO_W-1:0] q_reg  [QUO_W];
    logic [NW-1:0]    r_next [QUO_W];
    logic [QUO_W-1:0] q_next [QUO_W];

    always_comb
    begin
        logic [NW-1:0]    pr;
        logic [DEN_W-1:0] pd;
        logic [QUO_W-1:0] pq;
        logic [NW-1:0]    ds;
        for (int s = 0; s < QUO_W; s++)
        begin
            if (s == 0)
            begin
                pr = num;
                pd = den;
                pq = '0;
            end
            else
            begin
                pr = r_reg[s-1];
                pd = d_reg[s-1];
                pq = q_reg[s-1];
            end
            ds = NW'(pd) << (QUO_W - 1 - s);
            if (pr >= ds)
            begin
                r_next[s] = pr - ds;
                q_next[s] = {pq[QUO_W-2:0], 1'b1};
            end
            else
            begin
                r_next[s] = pr;
                q_next[s] = {pq[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < QUO_W; s++)
            begin
                r_reg[s] <= r_next[s];
                q_reg[s] <= q_next[s];
                d_reg[s] <= (s == 0) ? den : d_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign quo = q_reg[QUO_W-1];

endmodule

// ===== sv/sky_gradient_sun_glare_top.sv =====
// Sky gradient with sun glare: normalize ray, blend white to blue, add glare and bloom.
// Depends on skyglr_pkg, skyglr_sqrt, skyglr_div.
`timescale 1ns / 1ps

// Usage:
//   Input channel: dir_x/dir_y/dir_z with in_valid; a transaction completes when
//   in_valid is high and in_stall is low. Output channel: red/green/blue and
//   zero_direction with out_valid; a transaction completes when out_valid is high
//   and out_stall is low.
//   Sun direction is set through cfg_wr/cfg_idx/cfg_data while the block is idle.
//   Throughput: one transaction per cycle while in_stall is low. The path from input
//   transaction to out_valid runs through the 25-stage square root and the 19-stage
//   dividers plus the power chain of 13 multiply stages.
//   A two-entry output buffer follows the pipeline; the pipeline keeps moving
//   while that buffer has room, so a waiting result does not hold off input.
//   When the buffer is full and out_stall is high, the whole pipeline holds
//   and in_stall is raised; nothing is dropped or repeated.
//   Reset clears all valid flags and the buffer, and loads the sun direction
//   with (0, 0, 1.0).
module sky_gradient_sun_glare_top #(
    parameter int DIR_BITS = skyglr_pkg::DIR_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [DIR_BITS-1:0]          dir_x,
    input  logic signed [DIR_BITS-1:0]          dir_y,
    input  logic signed [DIR_BITS-1:0]          dir_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [skyglr_pkg::COLOR_W-1:0]      red,
    output logic [skyglr_pkg::COLOR_W-1:0]      green,
    output logic [skyglr_pkg::COLOR_W-1:0]      blue,
    output logic                                zero_direction,
    input  logic                                cfg_wr,
    input  logic [skyglr_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [skyglr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import skyglr_pkg::*;

    localparam int SH_W   = $clog2(DIR_BITS + 1);
    localparam int SQ_LAT = LEN_W;
    localparam int DV_LAT = QUO_W;
    localparam int NUM_W  = LEN_W + QUO_W;
    localparam int LAT    = 6 + SQ_LAT + DV_LAT + PW_STAGES + 1;

    typedef struct packed {
        logic               zero;
        logic               c2neg;
        logic [NORM_W-1:0]  c2mag;
        logic signed [34:0] dot;
    } sb_t;

    typedef struct packed {
        logic zero;
        logic c2neg;
        logic dotpos;
    } sd_t;

    logic en;
    logic push;
    logic pop;
    logic [LAT-1:0] vld_reg;
    logic [1:0]     cnt_reg;
    pix_t           fifo_reg [2];
    pix_t           pix_new;

    logic signed [15:0] sun_x_reg;
    logic signed [15:0] sun_y_reg;
    logic signed [15:0] sun_z_reg;

    logic [DIR_BITS-1:0] mag1_reg [3];
    logic [2:0]          neg1_reg;
    logic [DIR_BITS-1:0] mag2_reg [3];
    logic [2:0]          neg2_reg;
    logic [DIR_BITS-1:0] mx2_reg;
    logic [DIR_BITS-1:0] mag3_reg [3];
    logic [2:0]          neg3_reg;
    logic [SH_W-1:0]     sh3_reg;
    logic                zero3_reg;
    logic [NORM_W-1:0]   nm4_reg [3];
    logic [2:0]          neg4_reg;
    logic                zero4_reg;
    logic [31:0]         sq5_reg [3];
    logic signed [32:0]  sp5_reg [3];
    logic [NORM_W-1:0]   c2mag5_reg;
    logic                c2neg5_reg;
    logic                zero5_reg;
    logic [33:0]         sumsq6_reg;
    sb_t                 sb6_reg;
    sb_t                 sb_reg [SQ_LAT];
    sd_t                 sd_reg [DV_LAT];
    pw_t                 pl_reg [PW_STAGES];
    pw_t                 pl_next [PW_STAGES];
    logic [15:0]         base_reg [3];
    logic [15:0]         gt_reg [3];
    logic [15:0]         bt_reg [3];
    logic                zc_reg;

    logic [DIR_BITS-1:0] mag_next [3];
    logic [DIR_BITS-1:0] mx_next;
    logic [SH_W-1:0]     sh_next;
    logic signed [16:0]  cv [3];
    logic [LEN_W-1:0]    len8;
    logic [34:0]         dmag;
    logic [NUM_W-1:0]    num_uz;
    logic [NUM_W-1:0]    num_cs;
    logic [QUO_W-1:0]    q_uz;
    logic [QUO_W-1:0]    q_cs;
    logic [16:0]         qz;
    logic [17:0]         tw;
    pw_t                 p0_next;

    assign en       = (cnt_reg != 2'd2) || !out_stall;
    assign in_stall = !en;
    assign push     = vld_reg[LAT-1] && en;
    assign pop      = (cnt_reg != 2'd0) && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sun_x_reg <= '0;
            sun_y_reg <= '0;
            sun_z_reg <= SUN_Z_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                CFG_SUN_X: sun_x_reg <= cfg_data;
                CFG_SUN_Y: sun_y_reg <= cfg_data;
                CFG_SUN_Z: sun_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_comb
    begin
        mag_next[0] = dir_x[DIR_BITS-1] ? DIR_BITS'(~dir_x + 1'b1) : dir_x;
        mag_next[1] = dir_y[DIR_BITS-1] ? DIR_BITS'(~dir_y + 1'b1) : dir_y;
        mag_next[2] = dir_z[DIR_BITS-1] ? DIR_BITS'(~dir_z + 1'b1) : dir_z;
        mx_next = mag1_reg[0];
        if (mag1_reg[1] > mx_next)
        begin
            mx_next = mag1_reg[1];
        end
        if (mag1_reg[2] > mx_next)
        begin
            mx_next = mag1_reg[2];
        end
        sh_next = '0;
        for (int b = 0; b < DIR_BITS; b++)
        begin
            if (mx2_reg[b])
            begin
                sh_next = SH_W'(b + 1);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            cv[i] = neg4_reg[i] ? -$signed({1'b0, nm4_reg[i]}) : $signed({1'b0, nm4_reg[i]});
        end
    end

    // front end: magnitude, max, leading-one position, normalize, products, sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= mag_next[i];
                mag2_reg[i] <= mag1_reg[i];
                mag3_reg[i] <= mag2_reg[i];
                nm4_reg[i]  <= NORM_W'({mag3_reg[i], {NORM_W{1'b0}}} >> sh3_reg);
                sq5_reg[i]  <= 32'(nm4_reg[i]) * 32'(nm4_reg[i]);
            end
            neg1_reg   <= {dir_z[DIR_BITS-1], dir_y[DIR_BITS-1], dir_x[DIR_BITS-1]};
            neg2_reg   <= neg1_reg;
            mx2_reg    <= mx_next;
            neg3_reg   <= neg2_reg;
            sh3_reg    <= sh_next;
            zero3_reg  <= (mx2_reg == '0);
            neg4_reg   <= neg3_reg;
            zero4_reg  <= zero3_reg;
            sp5_reg[0] <= cv[0] * sun_x_reg;
            sp5_reg[1] <= cv[1] * sun_y_reg;
            sp5_reg[2] <= cv[2] * sun_z_reg;
            c2mag5_reg <= nm4_reg[2];
            c2neg5_reg <= neg4_reg[2];
            zero5_reg  <= zero4_reg;
            sumsq6_reg <= 34'(sq5_reg[0]) + 34'(sq5_reg[1]) + 34'(sq5_reg[2]);
            sb6_reg.dot   <= 35'(sp5_reg[0]) + 35'(sp5_reg[1]) + 35'(sp5_reg[2]);
            sb6_reg.c2mag <= c2mag5_reg;
            sb6_reg.c2neg <= c2neg5_reg;
            sb6_reg.zero  <= zero5_reg;
        end
    end

    skyglr_sqrt #(
        .ROOT_W (LEN_W)
    ) u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  ((2*LEN_W)'({sumsq6_reg, 16'b0})),
        .root (len8)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= sb6_reg;
            for (int i = 1; i < SQ_LAT; i++)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    always_comb
    begin
        dmag   = sb_reg[SQ_LAT-1].dot[34] ? 35'(-sb_reg[SQ_LAT-1].dot) : sb_reg[SQ_LAT-1].dot;
        num_uz = NUM_W'({sb_reg[SQ_LAT-1].c2mag, 24'b0});
        num_cs = NUM_W'({dmag, 10'b0});
    end

    skyglr_div #(
        .DEN_W (LEN_W),
        .QUO_W (QUO_W)
    ) u_div_z (
        .clk (clk),
        .en  (en),
        .num (num_uz),
        .den (len8),
        .quo (q_uz)
    );

    skyglr_div #(
        .DEN_W (LEN_W),
        .QUO_W (QUO_W)
    ) u_div_cos (
        .clk (clk),
        .en  (en),
        .num (num_cs),
        .den (len8),
        .quo (q_cs)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[0].zero   <= sb_reg[SQ_LAT-1].zero;
            sd_reg[0].c2neg  <= sb_reg[SQ_LAT-1].c2neg;
            sd_reg[0].dotpos <= !sb_reg[SQ_LAT-1].dot[34] && (sb_reg[SQ_LAT-1].dot != '0);
            for (int i = 1; i < DV_LAT; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    // t from the z component, clamped cosine into the power chain
    always_comb
    begin
        qz = (q_uz > QUO_W'(ONE_Q16)) ? ONE_Q16 : q_uz[16:0];
        tw = sd_reg[DV_LAT-1].c2neg ? (18'(ONE_Q16) - 18'(qz)) : (18'(ONE_Q16) + 18'(qz));
        p0_next      = '0;
        p0_next.t    = tw[17:1];
        p0_next.zero = sd_reg[DV_LAT-1].zero;
        if (sd_reg[DV_LAT-1].dotpos)
        begin
            p0_next.p[0] = (q_cs > QUO_W'(ONE_Q16)) ? ONE_Q16 : q_cs[16:0];
        end
        pl_next[0] = p0_next;
        for (int k = 1; k < PW_STAGES; k++)
        begin
            pl_next[k] = pw_step(k, pl_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < PW_STAGES; k++)
            begin
                pl_reg[k] <= pl_next[k];
            end
            base_reg[0] <= blend(TOP_R, pl_reg[PW_STAGES-1].t);
            base_reg[1] <= blend(TOP_G, pl_reg[PW_STAGES-1].t);
            base_reg[2] <= blend(TOP_B, pl_reg[PW_STAGES-1].t);
            gt_reg[0]   <= scale(GLR_R, pl_reg[PW_STAGES-1].acc);
            gt_reg[1]   <= scale(GLR_G, pl_reg[PW_STAGES-1].acc);
            gt_reg[2]   <= scale(GLR_B, pl_reg[PW_STAGES-1].acc);
            bt_reg[0]   <= scale(BLM_R, pl_reg[PW_STAGES-1].bloom);
            bt_reg[1]   <= scale(BLM_G, pl_reg[PW_STAGES-1].bloom);
            bt_reg[2]   <= scale(BLM_B, pl_reg[PW_STAGES-1].bloom);
            zc_reg      <= pl_reg[PW_STAGES-1].zero;
        end
    end

    always_comb
    begin
        pix_new.zero = zc_reg;
        if (zc_reg)
        begin
            pix_new.red   = '0;
            pix_new.green = '0;
            pix_new.blue  = '0;
        end
        else
        begin
            pix_new.red   = sat_sum(base_reg[0], gt_reg[0], bt_reg[0]);
            pix_new.green = sat_sum(base_reg[1], gt_reg[1], bt_reg[1]);
            pix_new.blue  = sat_sum(base_reg[2], gt_reg[2], bt_reg[2]);
        end
    end

    // two-entry output buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (push && (cnt_reg == 2'd1))
            begin
                fifo_reg[0] <= pix_new;
            end
            else
            begin
                fifo_reg[0] <= fifo_reg[1];
            end
            if (push && (cnt_reg == 2'd2))
            begin
                fifo_reg[1] <= pix_new;
            end
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                fifo_reg[0] <= pix_new;
            end
            else
            begin
                fifo_reg[1] <= pix_new;
            end
        end
    end

    assign out_valid      = (cnt_reg != 2'd0);
    assign red            = fifo_reg[0].red;
    assign green          = fifo_reg[0].green;
    assign blue           = fifo_reg[0].blue;
    assign zero_direction = fifo_reg[0].zero;

endmodule

// ===== tb/sv/sky_gradient_sun_glare_top_tb.sv =====
// Testbench for sky_gradient_sun_glare_top: drives ray directions, predicts sky colors.
// Depends on skyglr_pkg and the sky_gradient_sun_glare_top RTL.
`timescale 1ns / 1ps

module sky_gradient_sun_glare_top_tb;
    import skyglr_pkg::*;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } ray_t;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        zero;
    } color_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        zero_direction;
    logic        cfg_wr;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [15:0] cfg_data;

    logic signed [15:0] sun_x;
    logic signed [15:0] sun_y;
    logic signed [15:0] sun_z;

    ray_t   ray_q[$];
    color_t color_q[$];
    int     n_err;
    int     wait_in;
    int     wait_out;
    bit     hold_in;
    bit     in_acc;

    sky_gradient_sun_glare_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .red(red), .green(green), .blue(blue), .zero_direction(zero_direction),
        .cfg_wr(cfg_wr), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned q16_mul(input longint unsigned a,
                                                input longint unsigned b);
        return (a * b + 32768) >> 16;
    endfunction

    function automatic longint div_trunc(input longint num, input longint unsigned den);
        longint unsigned m;
        m = (num < 0) ? longint'(-num) : num;
        m = m / den;
        return (num < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [15:0] mix_channel(input longint unsigned top,
        input longint unsigned t, input longint unsigned gc, input longint unsigned g,
        input longint unsigned bc, input longint unsigned bl);
        longint unsigned v;
        v = (8192 * (65536 - t) + top * t + 32768) >> 16;
        v += (gc * g + 32768) >> 16;
        v += (bc * bl + 32768) >> 16;
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic color_t sky_color(input ray_t r);
        color_t o;
        longint unsigned mag[3];
        bit ng[3];
        longint c[3];
        longint unsigned mx, sq, len, t, p, p2, p4, p8, p16, p32, p64, p128, p256;
        longint unsigned glare, bloom;
        longint uz, dot, cs;
        ng[0] = r.x[15]; ng[1] = r.y[15]; ng[2] = r.z[15];
        mag[0] = ng[0] ? 65536 - longint'({1'b0, r.x}) : longint'({1'b0, r.x});
        mag[1] = ng[1] ? 65536 - longint'({1'b0, r.y}) : longint'({1'b0, r.y});
        mag[2] = ng[2] ? 65536 - longint'({1'b0, r.z}) : longint'({1'b0, r.z});
        mx = mag[0];
        if (mag[1] > mx) mx = mag[1];
        if (mag[2] > mx) mx = mag[2];
        if (mx == 0)
        begin
            o.red = 0; o.green = 0; o.blue = 0; o.zero = 1'b1;
            return o;
        end
        while (mx < 32768)
        begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        while (mx >= 65536)
        begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        for (int i = 0; i < 3; i++) c[i] = ng[i] ? -longint'(mag[i]) : longint'(mag[i]);
        sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = int_sqrt(sq << 16);
        uz = div_trunc(c[2] * 16777216, len);
        if (uz > 65536) uz = 65536;
        if (uz < -65536) uz = -65536;
        t = longint'(uz + 65536) >> 1;
        dot = c[0] * longint'(sun_x) + c[1] * longint'(sun_y) + c[2] * longint'(sun_z);
        cs = div_trunc(dot * 1024, len);
        glare = 0;
        bloom = 0;
        if (cs > 0)
        begin
            p = (cs > 65536) ? 65536 : cs;
            p2 = q16_mul(p, p);
            p4 = q16_mul(p2, p2);
            p8 = q16_mul(p4, p4);
            p16 = q16_mul(p8, p8);
            p32 = q16_mul(p16, p16);
            p64 = q16_mul(p32, p32);
            p128 = q16_mul(p64, p64);
            p256 = q16_mul(p128, p128);
            bloom = q16_mul(p8, p2);
            glare = q16_mul(q16_mul(q16_mul(q16_mul(q16_mul(p256, p128), p64),
                            p32), p16), p4);
        end
        o.red   = mix_channel(1638, t, 40960, glare, 4096, bloom);
        o.green = mix_channel(3277, t, 32768, glare, 2458, bloom);
        o.blue  = mix_channel(6554, t, 16384, glare, 819, bloom);
        o.zero  = 1'b0;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_err++;
    endtask

    // input transaction capture
    always @(posedge clk)
    begin
        in_acc <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            color_q.push_back(sky_color('{dir_x, dir_y, dir_z}));
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_acc)
                ;
            else if (wait_in > 0)
            begin
                wait_in <= wait_in - 1;
                in_valid <= 1'b0;
            end
            else if (ray_q.size() > 0 && !hold_in)
            begin
                ray_t r;
                r = ray_q.pop_front();
                dir_x <= r.x; dir_y <= r.y; dir_z <= r.z;
                in_valid <= 1'b1;
                wait_in <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (color_q.size() == 0)
                report_mismatch("unexpected transaction", 1, 0);
            else
            begin
                color_t e;
                e = color_q.pop_front();
                if (red !== e.red) report_mismatch("red", red, e.red);
                if (green !== e.green) report_mismatch("green", green, e.green);
                if (blue !== e.blue) report_mismatch("blue", blue, e.blue);
                if (zero_direction !== e.zero)
                    report_mismatch("zero_direction", zero_direction, e.zero);
            end
        end
    end

    always @(negedge clk)
    begin
        if (wait_out > 0)
        begin
            wait_out <= wait_out - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (out_valid)
                wait_out <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
        end
    end

    task automatic drain();
        while (ray_q.size() > 0 || in_valid || color_q.size() > 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_sun(input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic signed [15:0] z);
        logic signed [15:0] v[3];
        cfg_idx_t idx[3];
        v[0] = x; v[1] = y; v[2] = z;
        idx[0] = CFG_SUN_X; idx[1] = CFG_SUN_Y; idx[2] = CFG_SUN_Z;
        for (int i = 0; i < 3; i++)
        begin
            @(negedge clk);
            cfg_wr <= 1'b1;
            cfg_idx <= idx[i];
            cfg_data <= v[i];
        end
        @(negedge clk);
        cfg_wr <= 1'b0;
        sun_x = x; sun_y = y; sun_z = z;
    endtask

    function automatic logic signed [15:0] rnd_comp();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 15)) - 16'd8;
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2: return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                ray_q.push_back('{16'sd0, 16'sd0, 16'sd0});
            else
                ray_q.push_back('{rnd_comp(), rnd_comp(), rnd_comp()});
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        dir_x = 0; dir_y = 0; dir_z = 0;
        cfg_wr = 1'b0;
        cfg_idx = CFG_SUN_X;
        cfg_data = 0;
        n_err = 0;
        wait_in = 0;
        wait_out = 0;
        hold_in = 0;
        sun_x = 0; sun_y = 0; sun_z = 16384;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        ray_q.push_back('{16'sd0, 16'sd0, 16'sd0});
        ray_q.push_back('{16'sd0, 16'sd0, 16'sd1});
        ray_q.push_back('{16'sd0, 16'sd0, -16'sd1});
        ray_q.push_back('{16'sd0, 16'sd0, 16'sh7FFF});
        ray_q.push_back('{16'sd0, 16'sd0, 16'sh8000});
        ray_q.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
        ray_q.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        ray_q.push_back('{16'sh7FFF, 16'sd0, 16'sd0});
        ray_q.push_back('{16'sd0, 16'sh8000, 16'sd0});
        ray_q.push_back('{16'sd100, -16'sd100, 16'sd10000});
        ray_q.push_back('{-16'sd1, 16'sh7FFF, 16'sd1});
        ray_q.push_back('{16'sd3, 16'sd4, 16'sd12});
        add_random(200);
        drain();

        set_sun(16'sd16384, 16'sd0, 16'sd0);
        ray_q.push_back('{16'sh7FFF, 16'sd0, 16'sd0});
        ray_q.push_back('{16'sh8000, 16'sd0, 16'sd0});
        add_random(250);
        drain();

        set_sun(-16'sd16384, 16'sd0, 16'sd0);
        add_random(200);
        drain();
        hold_in = 1;
        add_random(50);
        repeat (20) @(posedge clk);
        hold_in = 0;
        drain();

        set_sun(16'sd0, -16'sd16384, 16'sd0);
        add_random(200);
        drain();

        set_sun(16'sd9459, 16'sd9459, 16'sd9459);
        add_random(200);
        drain();

        // non-unit sun: cosine saturates
        set_sun(16'sh7FFF, 16'sh7FFF, 16'sh8000);
        ray_q.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh8000});
        add_random(150);
        drain();

        set_sun(16'sd0, 16'sd0, -16'sd16384);
        add_random(180);
        drain();

        if (n_err == 0)
            $display("** sky_gradient_sun_glare_top: PASSED **");
        else
            $display("** sky_gradient_sun_glare_top: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("** sky_gradient_sun_glare_top: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/skyglr_pkg.sv
sv/skyglr_sqrt.sv
sv/skyglr_div.sv
sv/sky_gradient_sun_glare_top.sv
tb/sv/sky_gradient_sun_glare_top_tb.sv
